>>> sv/hue_selective_grayscale_assert.svh
// assertion macros for the hue selective grayscale block
// used by the top level; expects clk and rst in the including scope
`ifndef HUE_SELECTIVE_GRAYSCALE_ASSERT_SVH
`define HUE_SELECTIVE_GRAYSCALE_ASSERT_SVH

`ifndef ASSERT_OFF
`define HSG_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define HSG_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define HSG_ASSERT_ALWAYS(label, expr, msg)
`define HSG_ASSERT_IMPLY(label, ante, cons, msg)
`endif

`endif

>>> sv/hsg_pkg.sv
// shared types and constants of the hue selective grayscale block
// no dependencies; used by hsg_hue_pipe, hue_selective_grayscale and the testbench
`timescale 1ns / 1ps

package hsg_pkg;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       color_kept;
  } out_word_t;

  typedef struct packed {
    logic       ok;
    logic [8:0] hue;
  } hue_res_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BLUE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_TOL      = 2'd3;

  localparam logic [7:0] TARGET_RED_RST   = 8'd255;
  localparam logic [7:0] TARGET_GREEN_RST = 8'd0;
  localparam logic [7:0] TARGET_BLUE_RST  = 8'd0;
  localparam logic [7:0] HUE_TOL_RST      = 8'd30;

  localparam int unsigned LUMA_R = 13938;
  localparam int unsigned LUMA_G = 46869;
  localparam int unsigned LUMA_B = 4730;

  localparam int unsigned HUE_SECTOR = 15360;
  localparam int unsigned OFS_GREEN  = 120 * 256;
  localparam int unsigned OFS_BLUE   = 240 * 256;
  localparam int unsigned HUE_FULL   = 360;

  // quotient of the sector division never exceeds 15360
  localparam int unsigned QUOT_BITS      = 14;
  localparam int unsigned DIV_STEPS      = 2;
  localparam int unsigned DIV_STAGES     = QUOT_BITS / DIV_STEPS;
  localparam int unsigned HUE_LAT        = DIV_STAGES + 3;
  localparam int unsigned PIPE_STAGES    = HUE_LAT + 2;

endpackage

>>> sv/hsg_hue_pipe.sv
// pipelined integer hue of one rgb color, HUE_LAT stages, one color per cycle
// when en is all high; depends on hsg_pkg; stage k loads when en[k] is high
`timescale 1ns / 1ps

module hsg_hue_pipe (
  input  logic                          clk,
  input  logic [hsg_pkg::HUE_LAT-1:0]   en,
  input  hsg_pkg::in_word_t             color,
  output hsg_pkg::hue_res_t             result
);

  localparam int unsigned QB = hsg_pkg::QUOT_BITS;
  localparam int unsigned NS = hsg_pkg::DIV_STAGES;
  localparam int unsigned NJ = hsg_pkg::DIV_STEPS;

  typedef enum logic [1:0] {SECT_RED, SECT_GREEN, SECT_BLUE} sector_t;

  // stage 0: max, min, sector and difference
  logic [7:0]        r, g, b;
  logic [7:0]        hi_a, lo_a;
  logic signed [8:0] diff_a;
  sector_t           sect_a;

  sector_t           sect_q0;
  logic [7:0]        chroma_q0;
  logic signed [8:0] diff_q0;

  assign r = color.red_in;
  assign g = color.green_in;
  assign b = color.blue_in;

  always_comb begin
    // ties go to red, then green
    if (r >= g && r >= b) begin
      sect_a = SECT_RED;
      hi_a   = r;
      diff_a = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (g >= b) begin
      sect_a = SECT_GREEN;
      hi_a   = g;
      diff_a = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      sect_a = SECT_BLUE;
      hi_a   = b;
      diff_a = $signed({1'b0, r}) - $signed({1'b0, g});
    end
    lo_a = (r <= g) ? r : g;
    lo_a = (b < lo_a) ? b : lo_a;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sect_q0   <= sect_a;
      chroma_q0 <= hi_a - lo_a;
      diff_q0   <= diff_a;
    end
  end

  // stage 1: rounded numerator, split into sign and magnitude
  logic [22:0] dext_b, num_b, mag_b;

  logic [21:0] mag_q1;
  logic        neg_q1;
  logic [7:0]  chroma_q1;
  sector_t     sect_q1;

  always_comb begin
    dext_b = {{14{diff_q0[8]}}, diff_q0};
    num_b  = dext_b * 23'(hsg_pkg::HUE_SECTOR) + {16'b0, chroma_q0[7:1]};
    mag_b  = num_b[22] ? (~num_b + 23'd1) : num_b;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mag_q1    <= mag_b[21:0];
      neg_q1    <= num_b[22];
      chroma_q1 <= chroma_q0;
      sect_q1   <= sect_q0;
    end
  end

  // restoring divider, NJ quotient bits per stage; remainder stays below chroma
  logic [7:0]    rem_q    [NS];
  logic [QB-1:0] quo_q    [NS];
  logic [QB-1:0] mag_d_q  [NS];
  logic [7:0]    chroma_d [NS];
  logic          neg_d    [NS];
  sector_t       sect_d   [NS];

  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [7:0]    rem_in, rem_out, c_in;
    logic [QB-1:0] quo_in, quo_out, mag_in;
    logic          neg_in;
    sector_t       sect_in;

    if (s == 0) begin : g_first
      assign rem_in  = mag_q1[21:QB];
      assign quo_in  = '0;
      assign mag_in  = mag_q1[QB-1:0];
      assign c_in    = chroma_q1;
      assign neg_in  = neg_q1;
      assign sect_in = sect_q1;
    end else begin : g_rest
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign mag_in  = mag_d_q[s-1];
      assign c_in    = chroma_d[s-1];
      assign neg_in  = neg_d[s-1];
      assign sect_in = sect_d[s-1];
    end

    always_comb begin
      logic [8:0] trial;
      rem_out = rem_in;
      quo_out = quo_in;
      for (int j = 0; j < NJ; j++) begin
        trial = {rem_out, mag_in[QB-1-s*NJ-j]};
        if (trial >= {1'b0, c_in}) begin
          rem_out                = 8'(trial - {1'b0, c_in});
          quo_out[QB-1-s*NJ-j]   = 1'b1;
        end else begin
          rem_out = trial[7:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[2+s]) begin
        rem_q[s]    <= rem_out;
        quo_q[s]    <= quo_out;
        mag_d_q[s]  <= mag_in;
        chroma_d[s] <= c_in;
        neg_d[s]    <= neg_in;
        sect_d[s]   <= sect_in;
      end
    end
  end

  // last stage: sign, sector offset, floor shift and wrap into 0..359
  logic [17:0]       qs_p, ofs_p, sum_p;
  logic signed [9:0] deg_p, wrap_p;

  always_comb begin
    qs_p = neg_d[NS-1] ? (~{4'b0, quo_q[NS-1]} + 18'd1) : {4'b0, quo_q[NS-1]};
    unique case (sect_d[NS-1])
      SECT_RED:   ofs_p = 18'd0;
      SECT_GREEN: ofs_p = 18'(hsg_pkg::OFS_GREEN);
      SECT_BLUE:  ofs_p = 18'(hsg_pkg::OFS_BLUE);
      default:    ofs_p = 18'd0;
    endcase
    sum_p = qs_p + ofs_p;
    deg_p = $signed(sum_p[17:8]);
    if (deg_p >= $signed(10'(hsg_pkg::HUE_FULL))) begin
      wrap_p = deg_p - $signed(10'(hsg_pkg::HUE_FULL));
    end else if (deg_p < $signed(10'd0)) begin
      wrap_p = deg_p + $signed(10'(hsg_pkg::HUE_FULL));
    end else begin
      wrap_p = deg_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en[hsg_pkg::HUE_LAT-1]) begin
      result.ok  <= (chroma_d[NS-1] != 8'd0);
      result.hue <= wrap_p[8:0];
    end
  end

endmodule

>>> sv/hue_selective_grayscale.sv
// top level of the hue selective grayscale block: config registers, pixel and
// target hue pipes, luma path, keep decision; depends on hsg_pkg, hsg_hue_pipe
`timescale 1ns / 1ps

//  channel   handshake             payload        direction
//  cfg       cfg_write             cfg_index/data in, no back-pressure
//  in        in_valid / in_stall   in_word        in
//  out       out_valid / out_stall out_word       out
//
//  one pixel per clock sustained while out_stall stays low; a taken pixel passes
//  the 7 divider stages of the hue pipes plus 5 others before it shows at out_valid
//  rst clears the stage valid bits and loads the config reset values
//  each stage holds while the one after it is full and stalled, so bubbles
//  close up and in_stall rises only when every stage is full

module hue_selective_grayscale (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [hsg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hsg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  hsg_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output hsg_pkg::out_word_t                out_word
);

  `include "hue_selective_grayscale_assert.svh"

  localparam int unsigned HL = hsg_pkg::HUE_LAT;
  localparam int unsigned NP = hsg_pkg::PIPE_STAGES;

  // config registers
  logic [7:0] target_red, target_green, target_blue, hue_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_red    <= hsg_pkg::TARGET_RED_RST;
      target_green  <= hsg_pkg::TARGET_GREEN_RST;
      target_blue   <= hsg_pkg::TARGET_BLUE_RST;
      hue_tolerance <= hsg_pkg::HUE_TOL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hsg_pkg::CFG_TARGET_RED:   target_red    <= cfg_data;
        hsg_pkg::CFG_TARGET_GREEN: target_green  <= cfg_data;
        hsg_pkg::CFG_TARGET_BLUE:  target_blue   <= cfg_data;
        hsg_pkg::CFG_HUE_TOL:      hue_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when it is empty or its successor loads
  logic [NP-1:0] valid_q;
  logic [NP-1:0] en;

  assign en[NP-1] = !valid_q[NP-1] || !out_stall;
  for (genvar k = 0; k < NP - 1; k++) begin : g_en
    assign en[k] = !valid_q[k] || en[k+1];
  end

  assign in_stall  = !en[0];
  assign out_valid = valid_q[NP-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid;
      end
      for (int k = 1; k < NP; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // hue of the pixel and of the target, in lockstep
  hsg_pkg::in_word_t target_word;
  hsg_pkg::hue_res_t pix_hue, tgt_hue;

  assign target_word = '{red_in: target_red, green_in: target_green, blue_in: target_blue};

  hsg_hue_pipe u_pix_hue (
    .clk    (clk),
    .en     (en[HL-1:0]),
    .color  (in_word),
    .result (pix_hue)
  );

  hsg_hue_pipe u_tgt_hue (
    .clk    (clk),
    .en     (en[HL-1:0]),
    .color  (target_word),
    .result (tgt_hue)
  );

  // pixel delay line and luma path
  hsg_pkg::in_word_t pix_q [HL];
  logic [23:0]       prod_r_q, prod_g_q, prod_b_q;
  logic [24:0]       luma_sum;
  logic [7:0]        luma_clamp;
  logic [7:0]        luma_q [HL];

  always_comb begin
    luma_sum   = 25'(prod_r_q) + 25'(prod_g_q) + 25'(prod_b_q);
    luma_clamp = (luma_sum[24:16] > 9'd255) ? 8'hff : luma_sum[23:16];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pix_q[0]  <= in_word;
      prod_r_q  <= 24'(in_word.red_in) * 24'(hsg_pkg::LUMA_R);
      prod_g_q  <= 24'(in_word.green_in) * 24'(hsg_pkg::LUMA_G);
      prod_b_q  <= 24'(in_word.blue_in) * 24'(hsg_pkg::LUMA_B);
      luma_q[0] <= 8'd0;
    end
    if (en[1]) begin
      luma_q[1] <= luma_clamp;
    end
    for (int k = 1; k < HL; k++) begin
      if (en[k]) begin
        pix_q[k] <= pix_q[k-1];
      end
    end
    for (int k = 2; k < HL; k++) begin
      if (en[k]) begin
        luma_q[k] <= luma_q[k-1];
      end
    end
  end

  // circular hue distance and keep decision
  logic signed [9:0] d1, d2;
  logic [8:0]        hue_dist;
  logic              keep;

  always_comb begin
    d1 = $signed({1'b0, pix_hue.hue}) - $signed({1'b0, tgt_hue.hue});
    d2 = $signed({1'b0, tgt_hue.hue}) - $signed({1'b0, pix_hue.hue});
    if (d1 < $signed(10'd0)) begin
      d1 = d1 + $signed(10'(hsg_pkg::HUE_FULL));
    end
    if (d2 < $signed(10'd0)) begin
      d2 = d2 + $signed(10'(hsg_pkg::HUE_FULL));
    end
    hue_dist = (d1 < d2) ? d1[8:0] : d2[8:0];
    keep     = pix_hue.ok && tgt_hue.ok && (hue_dist <= 9'(hue_tolerance));
  end

  hsg_pkg::in_word_t pix_k;
  logic [7:0]        luma_k;
  logic              keep_k;

  always_ff @(posedge clk) begin
    if (en[HL]) begin
      pix_k  <= pix_q[HL-1];
      luma_k <= luma_q[HL-1];
      keep_k <= keep;
    end
    if (en[NP-1]) begin
      if (keep_k) begin
        out_word <= '{red_out: pix_k.red_in, green_out: pix_k.green_in,
                      blue_out: pix_k.blue_in, color_kept: 1'b1};
      end else begin
        out_word <= '{red_out: luma_k, green_out: luma_k,
                      blue_out: luma_k, color_kept: 1'b0};
      end
    end
  end

  // checks
  `HSG_ASSERT_IMPLY(a_stall_full, in_stall,
                    out_valid && out_stall && (&valid_q),
                    "stall with room")
  `HSG_ASSERT_IMPLY(a_grey_equal, out_valid && !out_word.color_kept,
                    (out_word.red_out == out_word.green_out) &&
                    (out_word.green_out == out_word.blue_out),
                    "grey word with unequal channels")
  `HSG_ASSERT_IMPLY(a_kept_chroma, out_valid && out_word.color_kept,
                    !((out_word.red_out == out_word.green_out) &&
                      (out_word.green_out == out_word.blue_out)),
                    "kept word without chroma")
  `HSG_ASSERT_IMPLY(a_hue_range, valid_q[HL-1] && pix_hue.ok,
                    pix_hue.hue < 9'(hsg_pkg::HUE_FULL),
                    "hue out of range")

endmodule

>>> tb/sv/tb_hue_selective_grayscale.sv
// self-checking testbench for hue_selective_grayscale: directed table, then random pixels
// checked against an in-bench hue and luma predictor; depends on hsg_pkg and the block rtl
`timescale 1ns / 1ps

module tb_hue_selective_grayscale;
  import hsg_pkg::*;

  localparam int SETTLE_CYCLES  = 2 * PIPE_STAGES;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 8;
  localparam int PHASE_PIXELS   = 190;

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [7:0]           val;
    in_word_t             px;
    logic                 has_want;
    out_word_t            want;
  } dir_row_t;

  localparam int DIR_ROWS = 40;

  // rows at reset config (target pure red, tolerance 30) come first
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd255, 8'd0, 8'd0}, 1'b1, '{8'd255, 8'd0, 8'd0, 1'b1}},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd255, 8'd255, 8'd255}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 1'b0}},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd0, 8'd255, 8'd0}, 1'b1,
      '{8'd182, 8'd182, 8'd182, 1'b0}},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd0, 8'd0, 8'd255}, 1'b1, '{8'd18, 8'd18, 8'd18, 1'b0}},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd255, 8'd255, 8'd0}, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd0, 8'd255, 8'd255}, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd255, 8'd0, 8'd255}, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd255, 8'd0, 8'd128}, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd128, 8'd128, 8'd128}, 1'b1,
      '{8'd128, 8'd128, 8'd128, 1'b0}},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd1, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_WRITE, CFG_HUE_TOL, 8'd0, '0, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd255, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd255, 8'd0, 8'd1}, 1'b0, '0},
    '{ROW_WRITE, CFG_HUE_TOL, 8'd180, '0, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd0, 8'd255, 8'd255}, 1'b0, '0},
    '{ROW_WRITE, CFG_HUE_TOL, 8'd255, '0, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd0, 8'd128, 8'd255}, 1'b0, '0},
    // grey target: everything goes to luma
    '{ROW_WRITE, CFG_TARGET_RED, 8'd0, '0, 1'b0, '0},
    '{ROW_WRITE, CFG_TARGET_GREEN, 8'd0, '0, 1'b0, '0},
    '{ROW_WRITE, CFG_TARGET_BLUE, 8'd0, '0, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd255, 8'd0, 8'd0}, 1'b1, '{8'd54, 8'd54, 8'd54, 1'b0}},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{ROW_WRITE, CFG_TARGET_RED, 8'd200, '0, 1'b0, '0},
    '{ROW_WRITE, CFG_TARGET_GREEN, 8'd200, '0, 1'b0, '0},
    '{ROW_WRITE, CFG_TARGET_BLUE, 8'd200, '0, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd10, 8'd200, 8'd30}, 1'b0, '0},
    // cyan target, green and blue tie for the max
    '{ROW_WRITE, CFG_TARGET_RED, 8'd0, '0, 1'b0, '0},
    '{ROW_WRITE, CFG_TARGET_GREEN, 8'd255, '0, 1'b0, '0},
    '{ROW_WRITE, CFG_TARGET_BLUE, 8'd255, '0, 1'b0, '0},
    '{ROW_WRITE, CFG_HUE_TOL, 8'd30, '0, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd0, 8'd255, 8'd255}, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd0, 8'd255, 8'd200}, 1'b0, '0},
    '{ROW_WRITE, CFG_TARGET_BLUE, 8'd0, '0, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd0, 8'd255, 8'd0}, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd255, 8'd255, 8'd0}, 1'b0, '0},
    '{ROW_WRITE, CFG_TARGET_GREEN, 8'd0, '0, 1'b0, '0},
    '{ROW_WRITE, CFG_TARGET_BLUE, 8'd255, '0, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd0, 8'd0, 8'd255}, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_RED, 8'd0, '{8'd255, 8'd0, 8'd255}, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_word;

  // shadow copy of the config registers
  logic [7:0] tgt_red   = TARGET_RED_RST;
  logic [7:0] tgt_green = TARGET_GREEN_RST;
  logic [7:0] tgt_blue  = TARGET_BLUE_RST;
  logic [7:0] hue_tol   = HUE_TOL_RST;

  out_word_t   expected_pixels [$];
  out_word_t   due_word;
  int          errors = 0;
  int          quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  hue_selective_grayscale dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // integer hue 0..359; returns 0 when the color has no chroma
  function automatic logic hue_of(input int r, input int g, input int b, output int hue);
    int lo, hi, c, num, h;
    lo = (r < g) ? r : g;
    hi = (r > g) ? r : g;
    lo = (b < lo) ? b : lo;
    hi = (b > hi) ? b : hi;
    c = hi - lo;
    hue = 0;
    if (c == 0) return 1'b0;
    if (hi == r) num = int'(HUE_SECTOR) * (g - b);
    else if (hi == g) num = int'(HUE_SECTOR) * (b - r);
    else num = int'(HUE_SECTOR) * (r - g);
    h = (num + (c >>> 1)) / c;
    if (hi != r) h += (hi == g) ? int'(OFS_GREEN) : int'(OFS_BLUE);
    h = h >>> 8;
    if (h >= int'(HUE_FULL)) h -= int'(HUE_FULL);
    else if (h < 0) h += int'(HUE_FULL);
    hue = h;
    return 1'b1;
  endfunction

  function automatic int hue_gap(input int a, input int b);
    int d1, d2;
    d1 = a - b;
    d2 = b - a;
    if (d1 < 0) d1 += int'(HUE_FULL);
    if (d2 < 0) d2 += int'(HUE_FULL);
    return (d1 < d2) ? d1 : d2;
  endfunction

  function automatic out_word_t predict_pixel(input in_word_t px);
    out_word_t   res;
    int          th, ph;
    logic        t_ok, p_ok;
    int unsigned y;
    t_ok = hue_of(tgt_red, tgt_green, tgt_blue, th);
    p_ok = hue_of(px.red_in, px.green_in, px.blue_in, ph);
    if (t_ok && p_ok && hue_gap(th, ph) <= int'(hue_tol)) begin
      res = '{px.red_in, px.green_in, px.blue_in, 1'b1};
    end else begin
      y = (LUMA_R * px.red_in + LUMA_G * px.green_in + LUMA_B * px.blue_in) >> 16;
      if (y > 255) y = 255;
      res = '{y[7:0], y[7:0], y[7:0], 1'b0};
    end
    return res;
  endfunction

  function automatic logic [7:0] clamp8(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // mix of uniform, near-target, grey, tied-max and saturated pixels
  function automatic in_word_t rand_pixel();
    in_word_t    px;
    logic [31:0] raw;
    int          v, w;
    case ($urandom_range(9))
      4, 5, 6: begin
        px.red_in   = clamp8(int'(tgt_red) + int'($urandom_range(60)) - 30);
        px.green_in = clamp8(int'(tgt_green) + int'($urandom_range(60)) - 30);
        px.blue_in  = clamp8(int'(tgt_blue) + int'($urandom_range(60)) - 30);
      end
      7: begin
        v = $urandom_range(255);
        px = '{v[7:0], v[7:0], v[7:0]};
      end
      8: begin
        v = $urandom_range(255);
        w = $urandom_range(v);
        case ($urandom_range(2))
          0: px = '{v[7:0], v[7:0], w[7:0]};
          1: px = '{w[7:0], v[7:0], v[7:0]};
          default: px = '{v[7:0], w[7:0], v[7:0]};
        endcase
      end
      9: begin
        px.red_in   = $urandom_range(1) ? 8'hff : 8'h00;
        px.green_in = $urandom_range(1) ? 8'hff : 8'h00;
        px.blue_in  = $urandom_range(1) ? 8'hff : 8'h00;
      end
      default: begin
        raw = $urandom;
        px = raw[23:0];
      end
    endcase
    return px;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_TARGET_RED:   tgt_red = val;
      CFG_TARGET_GREEN: tgt_green = val;
      CFG_TARGET_BLUE:  tgt_blue = val;
      CFG_HUE_TOL:      hue_tol = val;
      default: ;
    endcase
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(input in_word_t px, input logic has_want, input out_word_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_pixels.push_back(has_want ? want : predict_pixel(px));
  endtask

  task automatic check_field(input string fld, input int unsigned want_v, input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected output word, expected none, actual %h", $time, out_word);
        errors++;
      end else begin
        due_word = expected_pixels.pop_front();
        check_field("red_out", due_word.red_out, out_word.red_out);
        check_field("green_out", due_word.green_out, out_word.green_out);
        check_field("blue_out", due_word.blue_out, out_word.blue_out);
        check_field("color_kept", due_word.color_kept, out_word.color_kept);
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    out_stall <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_WRITE) write_reg(DIRECTED[i].idx, DIRECTED[i].val);
      else send_pixel(DIRECTED[i].px, DIRECTED[i].has_want, DIRECTED[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_reg(CFG_HUE_TOL, HUE_TOL_RST);
        1: write_reg(CFG_HUE_TOL, 8'd0);
        2: write_reg(CFG_HUE_TOL, 8'd180);
        3: write_reg(CFG_HUE_TOL, 8'd255);
        6: write_reg(CFG_HUE_TOL, 8'd5);
        7: write_reg(CFG_HUE_TOL, 8'($urandom_range(255)));
        default: write_reg(CFG_HUE_TOL, 8'($urandom_range(180)));
      endcase
      if (p == 5) begin
        // grey target for a whole phase
        write_reg(CFG_TARGET_RED, 8'd90);
        write_reg(CFG_TARGET_GREEN, 8'd90);
        write_reg(CFG_TARGET_BLUE, 8'd90);
      end else begin
        write_reg(CFG_TARGET_RED, 8'($urandom_range(255)));
        write_reg(CFG_TARGET_GREEN, 8'($urandom_range(255)));
        write_reg(CFG_TARGET_BLUE, 8'($urandom_range(255)));
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 84; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 84; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        // hold the sender until the pipe is empty once
        if (p == 2 && n == PHASE_PIXELS / 2) drain();
        send_pixel(rand_pixel(), 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
